[hdl/rvie_pkg.sv]
// ----------------------------------------------------------------------------
// rvie_pkg
// shared types and constants of the rv64im execute block
// ----------------------------------------------------------------------------
package rvie_pkg;

    localparam int XLEN          = 64;
    localparam int REG_ADDR_BITS = 5;

    // major opcodes
    localparam logic [6:0] OPC_LUI      = 7'h37;
    localparam logic [6:0] OPC_AUIPC    = 7'h17;
    localparam logic [6:0] OPC_JAL      = 7'h6f;
    localparam logic [6:0] OPC_JALR     = 7'h67;
    localparam logic [6:0] OPC_BRANCH   = 7'h63;
    localparam logic [6:0] OPC_LOAD     = 7'h03;
    localparam logic [6:0] OPC_STORE    = 7'h23;
    localparam logic [6:0] OPC_OP_IMM   = 7'h13;
    localparam logic [6:0] OPC_OP_IMM32 = 7'h1b;
    localparam logic [6:0] OPC_OP       = 7'h33;
    localparam logic [6:0] OPC_OP32     = 7'h3b;
    localparam logic [6:0] OPC_MISC_MEM = 7'h0f;
    localparam logic [6:0] OPC_SYSTEM   = 7'h73;

    localparam logic [6:0] F7_BASE   = 7'h00;
    localparam logic [6:0] F7_ALT    = 7'h20;
    localparam logic [6:0] F7_MULDIV = 7'h01;

    // mul/div funct3
    localparam logic [2:0] F3_MUL    = 3'd0;
    localparam logic [2:0] F3_MULH   = 3'd1;
    localparam logic [2:0] F3_MULHSU = 3'd2;
    localparam logic [2:0] F3_MULHU  = 3'd3;

    localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
    localparam logic [31:0] WORD_MRET   = 32'h3020_0073;
    localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

    localparam logic [11:0] CSR_MTVEC  = 12'h305;
    localparam logic [11:0] CSR_MEPC   = 12'h341;
    localparam logic [11:0] CSR_MCAUSE = 12'h342;

    localparam logic [REG_ADDR_BITS-1:0] REG_A0 = 5'd10;
    localparam logic [REG_ADDR_BITS-1:0] REG_A7 = 5'd17;
    localparam logic [XLEN-1:0] ECALL_GROUP_TOP = 64'd19;

    localparam logic [1:0] STATUS_NORMAL  = 2'd0;
    localparam logic [1:0] STATUS_ECALL   = 2'd1;
    localparam logic [1:0] STATUS_HALT    = 2'd2;
    localparam logic [1:0] STATUS_ILLEGAL = 2'd3;

    typedef struct packed {
        logic capture;
        logic csr_clear;
        logic md_start;
        logic trap_mepc;
        logic commit;
    } rvie_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic use_md;
        logic is_ecall;
        logic md_done;
        logic out_free;
    } rvie_stat_t;

    typedef struct packed {
        logic       div;
        logic       word;
        logic [2:0] f3;
    } md_req_t;

endpackage

[hdl/rvie_muldiv.sv]
// ----------------------------------------------------------------------------
// rvie_muldiv
// iterative multiplier (32x32 partial products) and radix-2 divider
// ----------------------------------------------------------------------------
module rvie_muldiv
    import rvie_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  md_req_t         req,
    input  logic [XLEN-1:0] opa,
    input  logic [XLEN-1:0] opb,
    output logic            done,
    output logic [XLEN-1:0] result
);

    localparam logic [1:0] MD_IDLE = 2'd0;
    localparam logic [1:0] MD_MUL  = 2'd1;
    localparam logic [1:0] MD_DIV  = 2'd2;
    localparam logic [1:0] MD_OUT  = 2'd3;

    logic [1:0]        st_reg, st_next;
    logic [5:0]        cnt_reg;
    md_req_t           req_reg;
    logic [XLEN-1:0]   a_reg, b_reg, rem_reg, quo_reg, result_reg;
    logic [2*XLEN-1:0] acc_reg;
    logic [XLEN-1:0]   pp_reg;
    logic [1:0]        sh_reg;
    logic              neg_q_reg, neg_r_reg, dz_reg;

    logic              sgn;
    logic [XLEN-1:0]   da, db, ua, ub;
    logic [31:0]       a_half, b_half;
    logic [1:0]        hsum;
    logic [2*XLEN-1:0] pp_shifted;
    logic [XLEN-1:0]   corr_a, corr_b;
    logic [XLEN:0]     rem_shift;
    logic [XLEN+1:0]   diff;
    logic [XLEN-1:0]   q_fix, r_fix, mul_pick, div_pick, final_val;

    // divide operand setup
    always_comb
    begin
        sgn = ~req.f3[0];
        if (req.word)
        begin
            da = sgn ? {{32{opa[31]}}, opa[31:0]} : {32'd0, opa[31:0]};
            db = sgn ? {{32{opb[31]}}, opb[31:0]} : {32'd0, opb[31:0]};
        end
        else
        begin
            da = opa;
            db = opb;
        end
        ua = (sgn && da[XLEN-1]) ? (XLEN'(0) - da) : da;
        ub = (sgn && db[XLEN-1]) ? (XLEN'(0) - db) : db;
    end

    // multiply step: partial product of two halves; divide step: shifted remainder minus divisor
    always_comb
    begin
        a_half     = cnt_reg[0] ? a_reg[63:32] : a_reg[31:0];
        b_half     = cnt_reg[1] ? b_reg[63:32] : b_reg[31:0];
        hsum       = {1'b0, cnt_reg[0]} + {1'b0, cnt_reg[1]};
        pp_shifted = {64'd0, pp_reg} << {sh_reg, 5'd0};
        corr_a     = ((req_reg.f3 == F3_MULH || req_reg.f3 == F3_MULHSU) && a_reg[XLEN-1])
                     ? b_reg : '0;
        corr_b     = (req_reg.f3 == F3_MULH && b_reg[XLEN-1]) ? a_reg : '0;
        rem_shift  = {rem_reg, quo_reg[XLEN-1]};
        diff       = {1'b0, rem_shift} - {2'b00, b_reg};
    end

    // result selection
    always_comb
    begin
        q_fix = neg_q_reg ? (XLEN'(0) - quo_reg) : quo_reg;
        r_fix = neg_r_reg ? (XLEN'(0) - rem_reg) : rem_reg;
        if (dz_reg)
        begin
            q_fix = '1;
            r_fix = a_reg;
        end
        mul_pick  = (req_reg.f3 == F3_MUL) ? acc_reg[XLEN-1:0] : acc_reg[2*XLEN-1:XLEN];
        div_pick  = req_reg.f3[1] ? r_fix : q_fix;
        final_val = req_reg.div ? div_pick : mul_pick;
        if (req_reg.word)
            final_val = {{32{final_val[31]}}, final_val[31:0]};
    end

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            MD_IDLE:
            begin
                if (start)
                    st_next = req.div ? MD_DIV : MD_MUL;
            end
            MD_MUL:
            begin
                if (cnt_reg == 6'd6)
                    st_next = MD_OUT;
            end
            MD_DIV:
            begin
                if (cnt_reg == 6'd63)
                    st_next = MD_OUT;
            end
            default:
            begin
                st_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            st_reg <= MD_IDLE;
        else
            st_reg <= st_next;
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            MD_IDLE:
            begin
                cnt_reg <= '0;
                if (start)
                begin
                    req_reg   <= req;
                    acc_reg   <= '0;
                    rem_reg   <= '0;
                    quo_reg   <= ua;
                    neg_q_reg <= sgn && (da[XLEN-1] ^ db[XLEN-1]);
                    neg_r_reg <= sgn && da[XLEN-1];
                    dz_reg    <= (db == '0);
                    a_reg     <= req.div ? da : opa;
                    b_reg     <= req.div ? ub : opb;
                end
            end
            MD_MUL:
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg < 6'd4)
                begin
                    pp_reg <= {32'd0, a_half} * {32'd0, b_half};
                    sh_reg <= hsum;
                end
                if (cnt_reg >= 6'd1 && cnt_reg <= 6'd4)
                    acc_reg <= acc_reg + pp_shifted;
                else if (cnt_reg == 6'd5)
                    acc_reg[2*XLEN-1:XLEN] <= acc_reg[2*XLEN-1:XLEN] - corr_a;
                else if (cnt_reg == 6'd6)
                    acc_reg[2*XLEN-1:XLEN] <= acc_reg[2*XLEN-1:XLEN] - corr_b;
            end
            MD_DIV:
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (!diff[XLEN+1])
                begin
                    rem_reg <= diff[XLEN-1:0];
                    quo_reg <= {quo_reg[XLEN-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_shift[XLEN-1:0];
                    quo_reg <= {quo_reg[XLEN-2:0], 1'b0};
                end
            end
            default:
            begin
                result_reg <= final_val;
            end
        endcase
    end

    assign done   = (st_reg == MD_OUT);
    assign result = result_reg;

endmodule

[hdl/rvie_ctrl.sv]
// ----------------------------------------------------------------------------
// rvie_ctrl
// sequencing state machine of the execute block
// ----------------------------------------------------------------------------
module rvie_ctrl
    import rvie_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  rvie_stat_t stat,
    output rvie_cmd_t  cmd
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_EXEC  = 3'd2;
    localparam logic [2:0] ST_MD    = 3'd3;
    localparam logic [2:0] ST_FIN   = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.csr_clear = 1'b1;
                if (stat.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
                if (in_valid)
                    state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (stat.use_md)
                begin
                    cmd.md_start = 1'b1;
                    state_next   = ST_MD;
                end
                else
                begin
                    cmd.trap_mepc = stat.is_ecall;
                    state_next    = ST_FIN;
                end
            end
            ST_MD:
            begin
                if (stat.md_done)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

endmodule

[hdl/rvie_datapath.sv]
// ----------------------------------------------------------------------------
// rvie_datapath
// register file, csr memory, alu, load tracking and output register
// ----------------------------------------------------------------------------
module rvie_datapath
    import rvie_pkg::*;
#(
    parameter int CSR_ADDRESS_BITS = 12
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  rvie_cmd_t       cmd,
    output rvie_stat_t      stat,
    input  logic            opcode,
    input  logic [31:0]     instruction,
    input  logic [XLEN-1:0] pc,
    input  logic [XLEN-1:0] load_data,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [XLEN-1:0] next_pc,
    output logic            mem_valid,
    output logic            mem_write,
    output logic [XLEN-1:0] mem_address,
    output logic [1:0]      mem_size_log2,
    output logic [XLEN-1:0] mem_write_data,
    output logic [1:0]      status,
    output logic [XLEN-1:0] halt_code
);

    localparam int CSR_DEPTH = 1 << CSR_ADDRESS_BITS;
    localparam logic [CSR_ADDRESS_BITS-1:0] MTVEC_A  = CSR_MTVEC[CSR_ADDRESS_BITS-1:0];
    localparam logic [CSR_ADDRESS_BITS-1:0] MEPC_A   = CSR_MEPC[CSR_ADDRESS_BITS-1:0];
    localparam logic [CSR_ADDRESS_BITS-1:0] MCAUSE_A = CSR_MCAUSE[CSR_ADDRESS_BITS-1:0];

    // item registers
    logic            op_reg;
    logic [31:0]     inst_reg;
    logic [XLEN-1:0] pc_reg, ld_data_reg;

    // register file
    logic [XLEN-1:0] rf_mem [0:31];
    logic [31:0]     rf_vld_reg;
    logic [XLEN-1:0] rf_a_reg, rf_b_reg;
    logic            rf_a_vld_reg, rf_b_vld_reg;
    logic [REG_ADDR_BITS-1:0] rf_ra, rf_rb, rf_wa;
    logic            rf_we;
    logic [XLEN-1:0] rf_wd;

    // csr memory
    logic [XLEN-1:0] csr_mem [0:CSR_DEPTH-1];
    logic [XLEN-1:0] csr_rd_reg;
    logic [CSR_ADDRESS_BITS-1:0] csr_ra, csr_wa, clr_idx_reg;
    logic            csr_we;
    logic [XLEN-1:0] csr_wd;

    // pending load
    logic                     ld_pend_reg;
    logic [REG_ADDR_BITS-1:0] ld_dst_reg;
    logic [2:0]               ld_mode_reg;

    // output register
    logic            out_valid_reg;
    logic [XLEN-1:0] nxt_pc_reg, maddr_reg, mwd_reg, halt_reg;
    logic            mv_reg, mw_reg;
    logic [1:0]      msize_reg, status_reg;

    // decode and execute
    logic [6:0]      opc, f7;
    logic [2:0]      f3;
    logic [REG_ADDR_BITS-1:0] rd;
    logic [XLEN-1:0] a, b, immi, imms, immb, immu, immj, pc4;
    logic [5:0]      sh6;
    logic [4:0]      sh5;
    logic [XLEN-1:0] sll64, srl64, sra64;
    logic [31:0]     sllw, srlw, sraw;
    logic            lts, ltu, take;
    logic [XLEN-1:0] val, nxt, maddr, mwd, halt, csr_src, csr_new, mcause_val, ld_ext;
    logic            wr, ill, mv, mw, is_csr, is_load, is_ecall, use_md;
    logic [1:0]      msize, st_code;
    logic [XLEN-1:0] md_result;
    logic            md_done;
    md_req_t         md_req;
    logic            sys_in, out_free;

    // read addresses come straight from the port at capture
    always_comb
    begin
        sys_in = (instruction[6:0] == OPC_SYSTEM) && (instruction[14:12] == 3'd0);
        rf_ra  = sys_in ? REG_A7 : instruction[19:15];
        rf_rb  = sys_in ? REG_A0 : instruction[24:20];
        if (instruction == WORD_MRET)
            csr_ra = MEPC_A;
        else if (sys_in)
            csr_ra = MTVEC_A;
        else
            csr_ra = instruction[20 +: CSR_ADDRESS_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= opcode;
            inst_reg    <= instruction;
            pc_reg      <= pc;
            ld_data_reg <= load_data;
            rf_a_reg    <= rf_mem[rf_ra];
            rf_b_reg    <= rf_mem[rf_rb];
            csr_rd_reg  <= csr_mem[csr_ra];
        end
        if (rf_we)
            rf_mem[rf_wa] <= rf_wd;
        if (csr_we)
            csr_mem[csr_wa] <= csr_wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_vld_reg   <= '0;
            rf_a_vld_reg <= 1'b0;
            rf_b_vld_reg <= 1'b0;
            clr_idx_reg  <= '0;
        end
        else
        begin
            if (cmd.capture)
            begin
                rf_a_vld_reg <= rf_vld_reg[rf_ra];
                rf_b_vld_reg <= rf_vld_reg[rf_rb];
            end
            if (rf_we)
                rf_vld_reg[rf_wa] <= 1'b1;
            if (cmd.csr_clear)
                clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    always_comb
    begin
        opc  = inst_reg[6:0];
        rd   = inst_reg[11:7];
        f3   = inst_reg[14:12];
        f7   = inst_reg[31:25];
        a    = rf_a_vld_reg ? rf_a_reg : '0;
        b    = rf_b_vld_reg ? rf_b_reg : '0;
        immi = {{52{inst_reg[31]}}, inst_reg[31:20]};
        imms = {{52{inst_reg[31]}}, inst_reg[31:25], inst_reg[11:7]};
        immb = {{51{inst_reg[31]}}, inst_reg[31], inst_reg[7], inst_reg[30:25],
                inst_reg[11:8], 1'b0};
        immu = {{32{inst_reg[31]}}, inst_reg[31:12], 12'd0};
        immj = {{43{inst_reg[31]}}, inst_reg[31], inst_reg[19:12], inst_reg[20],
                inst_reg[30:21], 1'b0};
        pc4  = pc_reg + 64'd4;
        sh6  = (opc == OPC_OP_IMM) ? inst_reg[25:20] : b[5:0];
        sh5  = (opc == OPC_OP_IMM32) ? inst_reg[24:20] : b[4:0];
        sll64 = a << sh6;
        srl64 = a >> sh6;
        sra64 = $signed(a) >>> sh6;
        sllw  = a[31:0] << sh5;
        srlw  = a[31:0] >> sh5;
        sraw  = $signed(a[31:0]) >>> sh5;
    end

    // instruction execute
    always_comb
    begin
        val     = '0;
        wr      = 1'b0;
        ill     = 1'b0;
        nxt     = pc4;
        st_code = STATUS_NORMAL;
        mv      = 1'b0;
        mw      = 1'b0;
        maddr   = '0;
        msize   = '0;
        mwd     = '0;
        halt    = '0;
        is_csr  = 1'b0;
        is_load = 1'b0;
        take    = 1'b0;
        lts     = $signed(a) < $signed(b);
        ltu     = a < b;
        case (opc)
            OPC_LUI:
            begin
                val = immu;
                wr  = 1'b1;
            end
            OPC_AUIPC:
            begin
                val = pc_reg + immu;
                wr  = 1'b1;
            end
            OPC_JAL:
            begin
                val = pc4;
                wr  = 1'b1;
                nxt = pc_reg + immj;
            end
            OPC_JALR:
            begin
                if (f3 != 3'd0)
                    ill = 1'b1;
                else
                begin
                    val = pc4;
                    wr  = 1'b1;
                    nxt = (a + immi) & ~64'd1;
                end
            end
            OPC_BRANCH:
            begin
                case (f3)
                    3'd0:    take = (a == b);
                    3'd1:    take = (a != b);
                    3'd4:    take = lts;
                    3'd5:    take = ~lts;
                    3'd6:    take = ltu;
                    3'd7:    take = ~ltu;
                    default: ill  = 1'b1;
                endcase
                if (take)
                    nxt = pc_reg + immb;
            end
            OPC_LOAD:
            begin
                if (f3 == 3'd7)
                    ill = 1'b1;
                else
                begin
                    mv      = 1'b1;
                    maddr   = a + immi;
                    msize   = f3[1:0];
                    is_load = 1'b1;
                end
            end
            OPC_STORE:
            begin
                if (f3[2])
                    ill = 1'b1;
                else
                begin
                    mv    = 1'b1;
                    mw    = 1'b1;
                    maddr = a + imms;
                    msize = f3[1:0];
                    mwd   = b;
                end
            end
            OPC_OP_IMM:
            begin
                wr = 1'b1;
                case (f3)
                    3'd0: val = a + immi;
                    3'd2: val = {63'd0, $signed(a) < $signed(immi)};
                    3'd3: val = {63'd0, a < immi};
                    3'd4: val = a ^ immi;
                    3'd6: val = a | immi;
                    3'd7: val = a & immi;
                    3'd1:
                    begin
                        if (inst_reg[31:26] == 6'd0)
                            val = sll64;
                        else
                            ill = 1'b1;
                    end
                    default:
                    begin
                        if (inst_reg[31:26] == 6'd0)
                            val = srl64;
                        else if (inst_reg[31:26] == 6'h10)
                            val = sra64;
                        else
                            ill = 1'b1;
                    end
                endcase
            end
            OPC_OP_IMM32:
            begin
                wr = 1'b1;
                if (f3 == 3'd0)
                    val = a + immi;
                else if (f3 == 3'd1 && f7 == F7_BASE)
                    val = {32'd0, sllw};
                else if (f3 == 3'd5 && f7 == F7_BASE)
                    val = {32'd0, srlw};
                else if (f3 == 3'd5 && f7 == F7_ALT)
                    val = {32'd0, sraw};
                else
                    ill = 1'b1;
                val = {{32{val[31]}}, val[31:0]};
            end
            OPC_OP:
            begin
                wr = 1'b1;
                if (f7 == F7_BASE)
                begin
                    case (f3)
                        3'd0:    val = a + b;
                        3'd1:    val = sll64;
                        3'd2:    val = {63'd0, lts};
                        3'd3:    val = {63'd0, ltu};
                        3'd4:    val = a ^ b;
                        3'd5:    val = srl64;
                        3'd6:    val = a | b;
                        default: val = a & b;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == 3'd0)
                    val = a - b;
                else if (f7 == F7_ALT && f3 == 3'd5)
                    val = sra64;
                else if (f7 == F7_MULDIV)
                    val = md_result;
                else
                    ill = 1'b1;
            end
            OPC_OP32:
            begin
                wr = 1'b1;
                if (f7 == F7_BASE && f3 == 3'd0)
                    val = a + b;
                else if (f7 == F7_ALT && f3 == 3'd0)
                    val = a - b;
                else if (f7 == F7_BASE && f3 == 3'd1)
                    val = {32'd0, sllw};
                else if (f7 == F7_BASE && f3 == 3'd5)
                    val = {32'd0, srlw};
                else if (f7 == F7_ALT && f3 == 3'd5)
                    val = {32'd0, sraw};
                else if (f7 == F7_MULDIV && (f3 == 3'd0 || f3[2]))
                    val = md_result;
                else
                    ill = 1'b1;
                val = {{32{val[31]}}, val[31:0]};
            end
            OPC_MISC_MEM:
            begin
                if (f3 != 3'd0)
                    ill = 1'b1;
            end
            OPC_SYSTEM:
            begin
                if (f3 == 3'd0)
                begin
                    // a7 sits on port a and a0 on port b for these words
                    if (inst_reg == WORD_ECALL)
                    begin
                        st_code = STATUS_ECALL;
                        nxt     = csr_rd_reg;
                    end
                    else if (inst_reg == WORD_MRET)
                        nxt = csr_rd_reg;
                    else if (inst_reg == WORD_EBREAK)
                    begin
                        st_code = STATUS_HALT;
                        nxt     = pc_reg;
                        halt    = b;
                    end
                    else
                        ill = 1'b1;
                end
                else if (f3 == 3'd4)
                    ill = 1'b1;
                else
                begin
                    is_csr = 1'b1;
                    val    = csr_rd_reg;
                    wr     = 1'b1;
                end
            end
            default:
            begin
                ill = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        is_ecall   = ~op_reg && (inst_reg == WORD_ECALL);
        use_md     = ~op_reg && (f7 == F7_MULDIV)
                     && ((opc == OPC_OP) || (opc == OPC_OP32 && (f3 == 3'd0 || f3[2])));
        md_req.div  = f3[2];
        md_req.word = (opc == OPC_OP32);
        md_req.f3   = f3;
        csr_src    = f3[2] ? {59'd0, inst_reg[19:15]} : a;
        case (f3[1:0])
            2'd1:    csr_new = csr_src;
            2'd2:    csr_new = csr_rd_reg | csr_src;
            default: csr_new = csr_rd_reg & ~csr_src;
        endcase
        mcause_val = (a >= 64'd1 && a <= ECALL_GROUP_TOP) ? 64'd1 : a;
        case (ld_mode_reg)
            3'd0:    ld_ext = {{56{ld_data_reg[7]}}, ld_data_reg[7:0]};
            3'd1:    ld_ext = {{48{ld_data_reg[15]}}, ld_data_reg[15:0]};
            3'd2:    ld_ext = {{32{ld_data_reg[31]}}, ld_data_reg[31:0]};
            3'd4:    ld_ext = {56'd0, ld_data_reg[7:0]};
            3'd5:    ld_ext = {48'd0, ld_data_reg[15:0]};
            3'd6:    ld_ext = {32'd0, ld_data_reg[31:0]};
            default: ld_ext = ld_data_reg;
        endcase
    end

    // write ports
    always_comb
    begin
        rf_we  = 1'b0;
        rf_wa  = rd;
        rf_wd  = val;
        csr_we = 1'b0;
        csr_wa = inst_reg[20 +: CSR_ADDRESS_BITS];
        csr_wd = csr_new;
        if (cmd.commit)
        begin
            if (op_reg)
            begin
                rf_we = ld_pend_reg && (ld_dst_reg != '0);
                rf_wa = ld_dst_reg;
                rf_wd = ld_ext;
            end
            else if (!ill)
            begin
                rf_we = wr && (rd != '0);
                if (is_ecall)
                begin
                    csr_we = 1'b1;
                    csr_wa = MCAUSE_A;
                    csr_wd = mcause_val;
                end
                else
                    csr_we = is_csr;
            end
        end
        if (cmd.csr_clear)
        begin
            csr_we = 1'b1;
            csr_wa = clr_idx_reg;
            csr_wd = '0;
        end
        else if (cmd.trap_mepc)
        begin
            csr_we = 1'b1;
            csr_wa = MEPC_A;
            csr_wd = pc_reg;
        end
    end

    // pending load and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ld_pend_reg   <= 1'b0;
            ld_dst_reg    <= '0;
            ld_mode_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
                if (op_reg)
                    ld_pend_reg <= 1'b0;
                else if (!ill && is_load)
                begin
                    ld_pend_reg <= 1'b1;
                    ld_dst_reg  <= rd;
                    ld_mode_reg <= f3;
                end
            end
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (op_reg || ill)
            begin
                nxt_pc_reg <= op_reg ? '0 : pc_reg;
                status_reg <= op_reg ? STATUS_NORMAL : STATUS_ILLEGAL;
                mv_reg     <= 1'b0;
                mw_reg     <= 1'b0;
                maddr_reg  <= '0;
                msize_reg  <= '0;
                mwd_reg    <= '0;
                halt_reg   <= '0;
            end
            else
            begin
                nxt_pc_reg <= nxt;
                status_reg <= st_code;
                mv_reg     <= mv;
                mw_reg     <= mw;
                maddr_reg  <= maddr;
                msize_reg  <= msize;
                mwd_reg    <= mwd;
                halt_reg   <= halt;
            end
        end
    end

    rvie_muldiv u_muldiv (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.md_start),
        .req    (md_req),
        .opa    (a),
        .opb    (b),
        .done   (md_done),
        .result (md_result)
    );

    assign out_free = ~out_valid_reg | ~out_stall;

    always_comb
    begin
        stat.clear_last = (clr_idx_reg == '1);
        stat.use_md     = use_md;
        stat.is_ecall   = is_ecall;
        stat.md_done    = md_done;
        stat.out_free   = out_free;
    end

    assign out_valid      = out_valid_reg;
    assign next_pc        = nxt_pc_reg;
    assign mem_valid      = mv_reg;
    assign mem_write      = mw_reg;
    assign mem_address    = maddr_reg;
    assign mem_size_log2  = msize_reg;
    assign mem_write_data = mwd_reg;
    assign status         = status_reg;
    assign halt_code      = halt_reg;

endmodule

[hdl/rv64im_instruction_execute.sv]
// ----------------------------------------------------------------------------
// rv64im_instruction_execute
// rv64im execute block with register file, csr memory and load tracking
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_stall) carries one item: opcode 0 executes
//   instruction at pc, opcode 1 returns load_data for the pending load
//   output channel (out_valid/out_stall) returns exactly one item per input:
//   next pc, an optional memory request, status and halt code
//   an item is taken when valid is high and stall is low
// timing
//   one item is in work at a time; in_stall is low only while idle
//   plain instructions and load returns: accept, execute, then finish and commit;
//   the next item is accepted on the same edge that takes the result
//   mul forms: wait in the mul/div state for the 32x32 partial product loop
//   div/rem forms: wait in the mul/div state for the one bit per cycle divider
// reset
//   after rst_n the csr memory is cleared one entry a cycle,
//   all 2**CSR_ADDRESS_BITS entries (4096 by default), with in_stall high;
//   the register file reads as zero through per-entry valid bits
// stall
//   a finished result waits in the output register while out_stall is high;
//   the next item is still accepted and waits to commit until the slot frees
// ----------------------------------------------------------------------------
module rv64im_instruction_execute
    import rvie_pkg::*;
#(
    parameter int CSR_ADDRESS_BITS = 12
)
(
    input  logic            clk,
    input  logic            rst_n,
    // input channel
    input  logic            in_valid,
    output logic            in_stall,
    input  logic            opcode,
    input  logic [31:0]     instruction,
    input  logic [XLEN-1:0] pc,
    input  logic [XLEN-1:0] load_data,
    // output channel
    output logic            out_valid,
    input  logic            out_stall,
    output logic [XLEN-1:0] next_pc,
    output logic            mem_valid,
    output logic            mem_write,
    output logic [XLEN-1:0] mem_address,
    output logic [1:0]      mem_size_log2,
    output logic [XLEN-1:0] mem_write_data,
    output logic [1:0]      status,
    output logic [XLEN-1:0] halt_code
);

    // command and status between sequencer and datapath
    rvie_cmd_t  cmd;
    rvie_stat_t stat;

    // sequencer: clear pass, accept, execute, mul/div wait, commit
    rvie_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: register file, csr memory, alu, mul/div unit, output register
    rvie_datapath #(
        .CSR_ADDRESS_BITS (CSR_ADDRESS_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .opcode         (opcode),
        .instruction    (instruction),
        .pc             (pc),
        .load_data      (load_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .next_pc        (next_pc),
        .mem_valid      (mem_valid),
        .mem_write      (mem_write),
        .mem_address    (mem_address),
        .mem_size_log2  (mem_size_log2),
        .mem_write_data (mem_write_data),
        .status         (status),
        .halt_code      (halt_code)
    );

`ifndef SYNTH
    // only one item in work at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while another is in work");

    // illegal words carry no memory request and no halt code
    a_illegal_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_ILLEGAL |-> !mem_valid && halt_code == '0)
        else $error("illegal result with side fields");

    // memory fields are zero without a request
    a_mem_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !mem_valid |-> mem_address == '0 && mem_write_data == '0 && !mem_write)
        else $error("memory fields set without request");
`endif

endmodule

[tb/rv64im_instruction_execute_tb.sv]
// ----------------------------------------------------------------------------
// rv64im_instruction_execute_tb
// self-checking regression of the rv64im execute block: a cycle-free
// predictor keeps its own register file, csr memory and load tracking and
// computes the expected result of every accepted item; a checker compares
// each returned result field by field with the oldest prediction
// ----------------------------------------------------------------------------
module rv64im_instruction_execute_tb;

    import rvie_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // item kinds on the opcode port
    localparam logic ITEM_EXEC        = 1'b0;
    localparam logic ITEM_LOAD_RETURN = 1'b1;

    // funct3 codes used by the stimulus and the predictor
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_DIV  = 3'd4;
    localparam logic [2:0] F3_DIVU = 3'd5;
    localparam logic [2:0] F3_REM  = 3'd6;
    localparam logic [2:0] F3_REMU = 3'd7;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;
    localparam logic [2:0] F3_LB   = 3'd0;
    localparam logic [2:0] F3_LH   = 3'd1;
    localparam logic [2:0] F3_LW   = 3'd2;
    localparam logic [2:0] F3_LD   = 3'd3;
    localparam logic [2:0] F3_LBU  = 3'd4;
    localparam logic [2:0] F3_LHU  = 3'd5;
    localparam logic [2:0] F3_LWU  = 3'd6;
    localparam logic [2:0] F3_BAD_LOAD  = 3'd7;
    localparam logic [2:0] F3_SD   = 3'd3;
    localparam logic [2:0] F3_PRIV = 3'd0;
    localparam logic [2:0] F3_CSRRW  = 3'd1;
    localparam logic [2:0] F3_CSRRS  = 3'd2;
    localparam logic [2:0] F3_CSRRC  = 3'd3;
    localparam logic [2:0] F3_BAD_SYS = 3'd4;
    localparam logic [2:0] F3_CSRRWI = 3'd5;
    localparam logic [2:0] F3_CSRRSI = 3'd6;
    localparam logic [2:0] F3_CSRRCI = 3'd7;
    localparam logic [6:0] F7_SRAI  = 7'h20;

    localparam logic [63:0] SIGN64   = 64'h8000_0000_0000_0000;
    localparam logic [63:0] ALL_ONES = '1;
    localparam logic [4:0]  REG_ZERO = 5'd0;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LONG_HOLD      = 300;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [63:0] next_pc;
        logic        mem_valid;
        logic        mem_write;
        logic [63:0] mem_address;
        logic [1:0]  mem_size_log2;
        logic [63:0] mem_write_data;
        logic [1:0]  status;
        logic [63:0] halt_code;
    } exec_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = ITEM_EXEC;
    logic [31:0] instruction = '0;
    logic [63:0] pc = '0;
    logic [63:0] load_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] next_pc;
    logic        mem_valid;
    logic        mem_write;
    logic [63:0] mem_address;
    logic [1:0]  mem_size_log2;
    logic [63:0] mem_write_data;
    logic [1:0]  status;
    logic [63:0] halt_code;

    // predictor state
    logic [63:0] arch_regs [32];
    logic [63:0] csr_mem [4096];
    logic        pend_load;
    logic [4:0]  pend_rd;
    logic [2:0]  pend_mode;

    exec_result_t expected_results[$];
    int          mismatch_count = 0;
    int          idle_cycles = 0;
    bit          hold_request = 1'b0;
    bit          calm = 1'b0;
    bit          gen_pending = 1'b0;

    rv64im_instruction_execute uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .opcode         (opcode),
        .instruction    (instruction),
        .pc             (pc),
        .load_data      (load_data),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .next_pc        (next_pc),
        .mem_valid      (mem_valid),
        .mem_write      (mem_write),
        .mem_address    (mem_address),
        .mem_size_log2  (mem_size_log2),
        .mem_write_data (mem_write_data),
        .status         (status),
        .halt_code      (halt_code)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // arithmetic helpers of the predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] sx32(input logic [63:0] x);
        return {{32{x[31]}}, x[31:0]};
    endfunction

    function automatic logic [63:0] div_signed(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
        if (b == 0) return ALL_ONES;
        if (a == SIGN64 && b == ALL_ONES) return a;   // overflow keeps dividend
        return a / b;
    endfunction

    function automatic logic [63:0] rem_signed(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
        if (b == 0) return a;
        if (a == SIGN64 && b == ALL_ONES) return '0;
        return a % b;
    endfunction

    function automatic logic [63:0] div_unsigned(input logic [63:0] a, input logic [63:0] b);
        return (b == 0) ? ALL_ONES : a / b;
    endfunction

    function automatic logic [63:0] rem_unsigned(input logic [63:0] a, input logic [63:0] b);
        return (b == 0) ? a : a % b;
    endfunction

    function automatic logic [63:0] shift_arith(input logic [63:0] a, input logic [5:0] sh);
        return $signed(a) >>> sh;
    endfunction

    function automatic logic [63:0] extend_loaded(input logic [63:0] d, input logic [2:0] mode);
        case (mode)
            F3_LB:   return {{56{d[7]}}, d[7:0]};
            F3_LH:   return {{48{d[15]}}, d[15:0]};
            F3_LW:   return sx32(d);
            F3_LBU:  return {56'b0, d[7:0]};
            F3_LHU:  return {48'b0, d[15:0]};
            F3_LWU:  return {32'b0, d[31:0]};
            default: return d;
        endcase
    endfunction

    // predictor state after reset: everything zero, no load waiting
    task automatic reset_predictor();
        for (int i = 0; i < 32; i++)
            arch_regs[i] = '0;
        for (int i = 0; i < 4096; i++)
            csr_mem[i] = '0;
        pend_load = 1'b0;
        pend_rd   = REG_ZERO;
        pend_mode = F3_LB;
    endtask

    // ------------------------------------------------------------------
    // predicts the result of one accepted item and updates the state
    // ------------------------------------------------------------------
    function automatic exec_result_t predict_execute(input logic op, input logic [31:0] w,
                                                     input logic [63:0] ipc,
                                                     input logic [63:0] ld);
        exec_result_t r;
        logic [6:0]   opc, f7;
        logic [4:0]   rd, rs1, rs2;
        logic [2:0]   f3;
        logic [63:0]  a, b, immi, val, nxt, t, src, a7;
        logic [127:0] prod;
        logic         wr, ill, take;
        logic [11:0]  caddr;
        r = '0;
        if (op == ITEM_LOAD_RETURN)
        begin
            if (pend_load)
            begin
                if (pend_rd != REG_ZERO) arch_regs[pend_rd] = extend_loaded(ld, pend_mode);
                pend_load = 1'b0;
            end
            return r;
        end
        opc = w[6:0]; rd = w[11:7]; f3 = w[14:12];
        rs1 = w[19:15]; rs2 = w[24:20]; f7 = w[31:25];
        a = arch_regs[rs1]; b = arch_regs[rs2];
        immi = {{52{w[31]}}, w[31:20]};
        val = '0; nxt = ipc + 64'd4; wr = 1'b0; ill = 1'b0;
        r.status = STATUS_NORMAL;
        case (opc)
            OPC_LUI:
            begin
                val = {{32{w[31]}}, w[31:12], 12'b0}; wr = 1'b1;
            end
            OPC_AUIPC:
            begin
                val = ipc + {{32{w[31]}}, w[31:12], 12'b0}; wr = 1'b1;
            end
            OPC_JAL:
            begin
                val = ipc + 64'd4; wr = 1'b1;
                nxt = ipc + {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
            end
            OPC_JALR:
            begin
                if (f3 != F3_ADD) ill = 1'b1;
                else
                begin
                    val = ipc + 64'd4; wr = 1'b1;
                    nxt = (a + immi) & ~64'd1;
                end
            end
            OPC_BRANCH:
            begin
                take = 1'b0;
                case (f3)
                    F3_BEQ:  take = (a == b);
                    F3_BNE:  take = (a != b);
                    F3_BLT:  take = ($signed(a) < $signed(b));
                    F3_BGE:  take = !($signed(a) < $signed(b));
                    F3_BLTU: take = (a < b);
                    F3_BGEU: take = (a >= b);
                    default: ill = 1'b1;
                endcase
                if (take)
                    nxt = ipc + {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
            end
            OPC_LOAD:
            begin
                if (f3 == F3_BAD_LOAD) ill = 1'b1;
                else
                begin
                    r.mem_valid = 1'b1; r.mem_address = a + immi; r.mem_size_log2 = f3[1:0];
                    pend_load = 1'b1; pend_rd = rd; pend_mode = f3;
                end
            end
            OPC_STORE:
            begin
                if (f3 > F3_SD) ill = 1'b1;
                else
                begin
                    r.mem_valid = 1'b1; r.mem_write = 1'b1;
                    r.mem_address = a + {{52{w[31]}}, w[31:25], w[11:7]};
                    r.mem_size_log2 = f3[1:0]; r.mem_write_data = b;
                end
            end
            OPC_OP_IMM:
            begin
                wr = 1'b1;
                case (f3)
                    F3_ADD:  val = a + immi;
                    F3_SLT:  val = ($signed(a) < $signed(immi)) ? 64'd1 : 64'd0;
                    F3_SLTU: val = (a < immi) ? 64'd1 : 64'd0;
                    F3_XOR:  val = a ^ immi;
                    F3_OR:   val = a | immi;
                    F3_AND:  val = a & immi;
                    F3_SLL:
                    begin
                        if (w[31:26] == 6'd0) val = a << w[25:20]; else ill = 1'b1;
                    end
                    default:
                    begin
                        if (w[31:26] == 6'd0) val = a >> w[25:20];
                        else if (w[31:26] == F7_SRAI[6:1]) val = shift_arith(a, w[25:20]);
                        else ill = 1'b1;
                    end
                endcase
            end
            OPC_OP_IMM32:
            begin
                wr = 1'b1;
                if (f3 == F3_ADD) val = sx32(a + immi);
                else if (f3 == F3_SLL && f7 == F7_BASE) val = sx32(a << rs2);
                else if (f3 == F3_SR && f7 == F7_BASE) val = sx32({32'b0, a[31:0]} >> rs2);
                else if (f3 == F3_SR && f7 == F7_ALT) val = sx32(shift_arith(sx32(a), {1'b0, rs2}));
                else ill = 1'b1;
            end
            OPC_OP:
            begin
                wr = 1'b1;
                if (f7 == F7_BASE)
                begin
                    case (f3)
                        F3_ADD:  val = a + b;
                        F3_SLL:  val = a << b[5:0];
                        F3_SLT:  val = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
                        F3_SLTU: val = (a < b) ? 64'd1 : 64'd0;
                        F3_XOR:  val = a ^ b;
                        F3_SR:   val = a >> b[5:0];
                        F3_OR:   val = a | b;
                        default: val = a & b;
                    endcase
                end
                else if (f7 == F7_ALT && f3 == F3_ADD) val = a - b;
                else if (f7 == F7_ALT && f3 == F3_SR) val = shift_arith(a, b[5:0]);
                else if (f7 == F7_MULDIV)
                begin
                    case (f3)
                        F3_MUL:    val = a * b;
                        F3_MULH:
                        begin
                            prod = {{64{a[63]}}, a} * {{64{b[63]}}, b}; val = prod[127:64];
                        end
                        F3_MULHSU:
                        begin
                            prod = {{64{a[63]}}, a} * {64'b0, b}; val = prod[127:64];
                        end
                        F3_MULHU:
                        begin
                            prod = {64'b0, a} * {64'b0, b}; val = prod[127:64];
                        end
                        F3_DIV:  val = div_signed(a, b);
                        F3_DIVU: val = div_unsigned(a, b);
                        F3_REM:  val = rem_signed(a, b);
                        default: val = rem_unsigned(a, b);
                    endcase
                end
                else ill = 1'b1;
            end
            OPC_OP32:
            begin
                wr = 1'b1;
                if (f7 == F7_BASE && f3 == F3_ADD) val = sx32(a + b);
                else if (f7 == F7_ALT && f3 == F3_ADD) val = sx32(a - b);
                else if (f7 == F7_BASE && f3 == F3_SLL) val = sx32(a << b[4:0]);
                else if (f7 == F7_BASE && f3 == F3_SR) val = sx32({32'b0, a[31:0]} >> b[4:0]);
                else if (f7 == F7_ALT && f3 == F3_SR)
                    val = sx32(shift_arith(sx32(a), {1'b0, b[4:0]}));
                else if (f7 == F7_MULDIV && f3 == F3_MUL) val = sx32(a * b);
                else if (f7 == F7_MULDIV && f3 == F3_DIV) val = sx32(div_signed(sx32(a), sx32(b)));
                else if (f7 == F7_MULDIV && f3 == F3_DIVU)
                    val = sx32(div_unsigned({32'b0, a[31:0]}, {32'b0, b[31:0]}));
                else if (f7 == F7_MULDIV && f3 == F3_REM) val = sx32(rem_signed(sx32(a), sx32(b)));
                else if (f7 == F7_MULDIV && f3 == F3_REMU)
                    val = sx32(rem_unsigned({32'b0, a[31:0]}, {32'b0, b[31:0]}));
                else ill = 1'b1;
            end
            OPC_MISC_MEM: if (f3 != F3_PRIV) ill = 1'b1;
            OPC_SYSTEM:
            begin
                if (f3 == F3_PRIV)
                begin
                    if (w == WORD_ECALL)
                    begin
                        a7 = arch_regs[REG_A7];
                        csr_mem[CSR_MEPC] = ipc;
                        csr_mem[CSR_MCAUSE] = (a7 >= 64'd1 && a7 <= ECALL_GROUP_TOP) ? 64'd1 : a7;
                        nxt = csr_mem[CSR_MTVEC];
                        r.status = STATUS_ECALL;
                    end
                    else if (w == WORD_MRET) nxt = csr_mem[CSR_MEPC];
                    else if (w == WORD_EBREAK)
                    begin
                        r.status = STATUS_HALT; nxt = ipc; r.halt_code = arch_regs[REG_A0];
                    end
                    else ill = 1'b1;
                end
                else if (f3 == F3_BAD_SYS) ill = 1'b1;
                else
                begin
                    caddr = w[31:20];
                    src = f3[2] ? {59'b0, rs1} : a;
                    t = csr_mem[caddr];
                    case (f3[1:0])
                        2'd1:    csr_mem[caddr] = src;
                        2'd2:    csr_mem[caddr] = t | src;
                        default: csr_mem[caddr] = t & ~src;
                    endcase
                    val = t; wr = 1'b1;
                end
            end
            default: ill = 1'b1;
        endcase
        if (ill)
        begin
            r = '0; r.next_pc = ipc; r.status = STATUS_ILLEGAL;
            return r;
        end
        if (wr && rd != REG_ZERO) arch_regs[rd] = val;
        r.next_pc = nxt;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // predictor and checker, both on the accepting clock edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        exec_result_t got, want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                got = '{next_pc, mem_valid, mem_write, mem_address, mem_size_log2,
                        mem_write_data, status, halt_code};
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result %p", got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.next_pc !== want.next_pc || got.mem_valid !== want.mem_valid
                        || got.mem_write !== want.mem_write
                        || got.mem_address !== want.mem_address
                        || got.mem_size_log2 !== want.mem_size_log2
                        || got.mem_write_data !== want.mem_write_data
                        || got.status !== want.status || got.halt_code !== want.halt_code)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                            $display("mismatch at %0t\n  expected %p\n  actual   %p",
                                     $realtime, want, got);
                    end
                end
            end
            // predict after checking: a result never leaves in its own accept cycle
            if (in_valid && !in_stall)
                expected_results.push_back(predict_execute(opcode, instruction, pc, load_data));
        end
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d results outstanding",
                         expected_results.size());
                $display("rv64im_instruction_execute regression: fail");
                $finish;
            end
        end
    end

    // result side: random stalls, rare long ones, one long hold on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_request = 1'b0;
                out_stall <= 1'b0;
            end
            else if (calm) out_stall <= 1'b0;
            else if ($urandom_range(0, 199) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(20, 60)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else out_stall <= ($urandom_range(0, 99) < 20);
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // offers one item until taken, then maybe idles
    task automatic send_item(input logic op, input logic [31:0] w,
                             input logic [63:0] p, input logic [63:0] d);
        int gap;
        in_valid <= 1'b1; opcode <= op; instruction <= w; pc <= p; load_data <= d;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic exec_word(input logic [31:0] w);
        send_item(ITEM_EXEC, w, {$urandom, $urandom}, {$urandom, $urandom});
    endtask

    task automatic return_load(input logic [63:0] d);
        send_item(ITEM_LOAD_RETURN, $urandom, {$urandom, $urandom}, d);
    endtask

    // stop offering, then wait until every result is back
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] r_word(input logic [6:0] f7, input logic [4:0] rs2,
                                           input logic [4:0] rs1, input logic [2:0] f3,
                                           input logic [4:0] rd, input logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] i_word(input logic [11:0] imm, input logic [4:0] rs1,
                                           input logic [2:0] f3, input logic [4:0] rd,
                                           input logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [63:0] pick_data();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return SIGN64;
            3:       return 64'(ALL_ONES >> 1);
            4:       return 64'($urandom_range(0, 40));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(0, 1) != 0) ? 5'($urandom_range(0, 7)) : 5'($urandom);
    endfunction

    function automatic logic [11:0] pick_csr();
        case ($urandom_range(0, 4))
            0:       return CSR_MTVEC;
            1:       return CSR_MEPC;
            2:       return CSR_MCAUSE;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic logic [6:0] pick_f7();
        case ($urandom_range(0, 4))
            0, 1:    return F7_MULDIV;
            2:       return F7_ALT;
            3:       return F7_BASE;
            default: return 7'($urandom);
        endcase
    endfunction

    // one random instruction word, biased toward legal forms
    function automatic logic [31:0] random_word();
        logic [31:0] u;
        logic [2:0]  f3;
        u = $urandom;
        f3 = 3'($urandom);
        case ($urandom_range(0, 15))
            0:  return {u[31:7], ($urandom_range(0, 1) != 0) ? OPC_LUI : OPC_AUIPC};
            1:  return {u[31:7], OPC_JAL};
            2:  return i_word(u[31:20], pick_reg(),
                              ($urandom_range(0, 4) != 0) ? F3_ADD : f3, pick_reg(), OPC_JALR);
            3:  return {u[31:25], pick_reg(), pick_reg(), f3, u[11:7], OPC_BRANCH};
            4:  return i_word(u[31:20], pick_reg(), f3, pick_reg(), OPC_LOAD);
            5:  return {u[31:25], pick_reg(), pick_reg(), f3, u[11:7], OPC_STORE};
            6, 7:
            begin
                if (f3 == F3_SLL || f3 == F3_SR)
                    return r_word(($urandom_range(0, 3) == 0) ? 7'($urandom)
                                  : {u[31] & u[30], 6'b0} | {1'b0, u[31] ? 6'h20 : 6'h00},
                                  u[24:20], pick_reg(), f3, pick_reg(), OPC_OP_IMM);
                return i_word(u[31:20], pick_reg(), f3, pick_reg(), OPC_OP_IMM);
            end
            8:  return r_word(($urandom_range(0, 3) == 0) ? 7'($urandom)
                              : (u[0] ? F7_ALT : F7_BASE),
                              u[24:20], pick_reg(), f3, pick_reg(), OPC_OP_IMM32);
            9, 10: return r_word(pick_f7(), pick_reg(), pick_reg(), f3, pick_reg(), OPC_OP);
            11: return r_word(pick_f7(), pick_reg(), pick_reg(), f3, pick_reg(), OPC_OP32);
            12: return {u[31:15], ($urandom_range(0, 3) != 0) ? F3_PRIV : f3, u[11:7],
                        OPC_MISC_MEM};
            13: return i_word(pick_csr(), pick_reg(), f3, pick_reg(), OPC_SYSTEM);
            14: case ($urandom_range(0, 4))
                    0, 1:    return WORD_ECALL;
                    2:       return WORD_MRET;
                    3:       return WORD_EBREAK;
                    default: return {u[31:15], F3_PRIV, u[11:7], OPC_SYSTEM};
                endcase
            default: return u;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // loads, the pending-load cases, multiply/divide corners and shift corners
    task automatic test_memory_and_muldiv();
        return_load(ALL_ONES);                                   // nothing pending
        exec_word(i_word(12'h000, 5'd0, F3_LD, 5'd1, OPC_LOAD));
        return_load(SIGN64);                                     // x1 = most negative
        exec_word(i_word(12'hfff, 5'd1, F3_LD, 5'd2, OPC_LOAD));
        return_load(ALL_ONES);                                   // x2 = -1
        exec_word(i_word(12'h7ff, 5'd2, F3_LB, 5'd0, OPC_LOAD));
        return_load(ALL_ONES);                                   // load to x0 dropped
        exec_word(i_word(12'h800, 5'd1, F3_LW, 5'd5, OPC_LOAD));
        exec_word(r_word(F7_BASE, 5'd1, 5'd5, F3_ADD, 5'd6, OPC_OP));  // reads old x5
        exec_word(i_word(12'h010, 5'd1, F3_LHU, 5'd5, OPC_LOAD));     // replaces pending
        return_load(64'h1234_5678_ffff_8081);
        exec_word({7'h7f, 5'd2, 5'd1, F3_SD, 5'h1f, OPC_STORE});
        exec_word(r_word(F7_MULDIV, 5'd2, 5'd1, F3_DIV, 5'd7, OPC_OP));   // overflow
        exec_word(r_word(F7_MULDIV, 5'd2, 5'd1, F3_REM, 5'd8, OPC_OP));
        exec_word(r_word(F7_MULDIV, 5'd0, 5'd1, F3_DIVU, 5'd9, OPC_OP));  // by zero
        exec_word(r_word(F7_MULDIV, 5'd0, 5'd1, F3_REMU, 5'd9, OPC_OP));
        exec_word(r_word(F7_MULDIV, 5'd2, 5'd1, F3_MULH, 5'd10, OPC_OP));
        exec_word(r_word(F7_MULDIV, 5'd2, 5'd1, F3_MULHSU, 5'd11, OPC_OP));
        exec_word(r_word(F7_MULDIV, 5'd2, 5'd2, F3_MULHU, 5'd12, OPC_OP));
        exec_word(r_word(F7_MULDIV, 5'd2, 5'd1, F3_DIV, 5'd13, OPC_OP32));
        exec_word(r_word(F7_BASE, 5'd2, 5'd2, F3_SLL, 5'd14, OPC_OP));    // amount masked
        exec_word(r_word(F7_ALT, 5'd2, 5'd1, F3_SR, 5'd15, OPC_OP32));
        exec_word(r_word(F7_ALT, 5'd31, 5'd1, F3_SR, 5'd16, OPC_OP_IMM32));
        exec_word(r_word(F7_SRAI | 7'h01, 5'd31, 5'd1, F3_SR, 5'd16, OPC_OP_IMM));
        wait_drain();
    endtask

    // csr forms, traps, halts and illegal words
    task automatic test_system();
        exec_word(i_word(CSR_MTVEC, 5'd31, F3_CSRRWI, 5'd3, OPC_SYSTEM));
        exec_word(i_word(CSR_MTVEC, 5'd1, F3_CSRRS, 5'd3, OPC_SYSTEM));
        exec_word(i_word(CSR_MTVEC, 5'd4, F3_CSRRCI, 5'd4, OPC_SYSTEM));
        exec_word(i_word(12'hfff, 5'd2, F3_CSRRW, 5'd4, OPC_SYSTEM));
        exec_word(i_word(12'hfff, 5'd2, F3_CSRRC, 5'd4, OPC_SYSTEM));
        exec_word(i_word(12'hfff, 5'd1, F3_CSRRSI, 5'd4, OPC_SYSTEM));
        exec_word(WORD_ECALL);                                     // a7 zero
        exec_word(i_word(12'd19, 5'd0, F3_ADD, REG_A7, OPC_OP_IMM));
        exec_word(WORD_ECALL);                                     // top of group
        exec_word(i_word(12'd20, 5'd0, F3_ADD, REG_A7, OPC_OP_IMM));
        exec_word(WORD_ECALL);                                     // past the group
        exec_word(WORD_MRET);
        exec_word(i_word(12'h800, 5'd2, F3_ADD, REG_A0, OPC_OP_IMM));
        exec_word(WORD_EBREAK);
        exec_word(i_word(12'h000, 5'd0, F3_PRIV, 5'd0, OPC_MISC_MEM));   // fence
        exec_word(i_word(12'h000, 5'd1, F3_BAD_LOAD, 5'd3, OPC_LOAD));
        exec_word({7'h00, 5'd2, 5'd1, 3'd4, 5'd0, OPC_STORE});
        exec_word(i_word(CSR_MEPC, 5'd1, F3_BAD_SYS, 5'd3, OPC_SYSTEM));
        exec_word(r_word(7'h7f, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_OP));
        exec_word(32'h1050_0073);                                  // unknown system word
        exec_word(32'hffff_ffff);
        exec_word(32'h0000_0000);
        wait_drain();
    endtask

    // mostly well-formed traffic: loads usually followed by their return
    task automatic test_random_program(input int count);
        logic [31:0] w;
        for (int i = 0; i < count; i++)
        begin
            if (gen_pending && $urandom_range(0, 3) != 0)
            begin
                return_load(pick_data());
                gen_pending = 1'b0;
            end
            else if ($urandom_range(0, 24) == 0)
            begin
                return_load(pick_data());
                gen_pending = 1'b0;
            end
            else
            begin
                w = random_word();
                if (w[6:0] == OPC_LOAD && w[14:12] != F3_BAD_LOAD) gen_pending = 1'b1;
                exec_word(w);
            end
        end
    endtask

    // result side held off while items keep coming, then a full drain
    task automatic test_backpressure();
        hold_request = 1'b1;
        test_random_program(20);
        wait_drain();
    endtask

    // back-to-back traffic with no gaps on either side
    task automatic test_full_rate();
        calm = 1'b1;
        test_random_program(150);
        calm = 1'b0;
    endtask

    initial
    begin
        reset_predictor();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_memory_and_muldiv();
        test_system();
        test_random_program(500);
        test_backpressure();
        test_full_rate();
        wait_drain();
        test_random_program(680);
        wait_drain();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("rv64im_instruction_execute regression: pass");
        else
            $display("rv64im_instruction_execute regression: fail");
        $finish;
    end

endmodule
